@@ sv/upd_pkg.sv @@
// Shared types, character constants and helper functions for the URL percent decoder.
package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;
	localparam logic [15:0] CAPACITY_RESET = 16'd65;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} word_t;

	typedef struct packed {
		word_t       w0;
		word_t       w1;
		logic [1:0]  n;
		logic [1:0]  held_cnt;
		logic [7:0]  held_b0;
		logic [7:0]  held_b1;
		logic [15:0] emitted;
	} dec_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
			((c >= 8'h61) && (c <= 8'h66));
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] r;
		if (c <= 8'h39) begin
			r = c[3:0];
		end else begin
			r = c[3:0] + HEX_ALPHA_ADJ;
		end
		return r;
	endfunction

	function automatic logic [7:0] map_plus(input logic [7:0] c);
		logic [7:0] r;
		r = (c == CH_PLUS) ? CH_SPACE : c;
		return r;
	endfunction

endpackage

@@ sv/upd_decode.sv @@
// Combinational decode of one input byte against the held lookahead and the emit budget.
module upd_decode (
	input  logic [1:0]    held_cnt,
	input  logic [7:0]    held_b0,
	input  logic [7:0]    held_b1,
	input  logic [15:0]   emitted,
	input  logic [15:0]   capacity,
	input  logic [7:0]    in_byte,
	input  logic          in_has_byte,
	input  logic          in_last,
	output upd_pkg::dec_t dec
);

	logic [7:0]  cand0;
	logic [7:0]  cand1;
	logic        cv0;
	logic        cv1;
	logic [1:0]  nh;
	logic [7:0]  nb0;
	logic [7:0]  nb1;
	logic [16:0] e1;
	logic [16:0] e2;
	logic        ok0;
	logic        ok1;
	logic [1:0]  k;

	always_comb begin
		cand0 = 8'd0;
		cand1 = 8'd0;
		cv0   = 1'b0;
		cv1   = 1'b0;
		nh    = held_cnt;
		nb0   = held_b0;
		nb1   = held_b1;
		if (in_has_byte || in_last) begin
			case (held_cnt)
				2'd0: begin
					if (in_has_byte) begin
						if ((in_byte == upd_pkg::CH_PERCENT) && !in_last) begin
							nh  = 2'd1;
							nb0 = in_byte;
						end else begin
							cand0 = upd_pkg::map_plus(in_byte);
							cv0   = 1'b1;
						end
					end
				end
				2'd1: begin
					if (in_has_byte && !in_last) begin
						nh  = 2'd2;
						nb1 = in_byte;
					end else begin
						cand0 = upd_pkg::CH_PERCENT;
						cv0   = 1'b1;
						cand1 = upd_pkg::map_plus(in_byte);
						cv1   = in_has_byte;
					end
				end
				2'd2: begin
					if (!in_has_byte) begin
						cand0 = upd_pkg::CH_PERCENT;
						cv0   = 1'b1;
						cand1 = upd_pkg::map_plus(held_b1);
						cv1   = 1'b1;
					end else if (upd_pkg::is_hex(held_b1) && upd_pkg::is_hex(in_byte)) begin
						cand0 = {upd_pkg::hex_val(held_b1), upd_pkg::hex_val(in_byte)};
						cv0   = 1'b1;
						nh    = 2'd0;
					end else if (held_b1 == upd_pkg::CH_PERCENT) begin
						if (!in_last) begin
							nh  = 2'd2;
							nb0 = held_b1;
							nb1 = in_byte;
						end else begin
							cand0 = upd_pkg::CH_PERCENT;
							cv0   = 1'b1;
							cand1 = upd_pkg::map_plus(in_byte);
							cv1   = 1'b1;
						end
					end else begin
						cand0 = upd_pkg::map_plus(held_b1);
						cv0   = 1'b1;
						if ((in_byte == upd_pkg::CH_PERCENT) && !in_last) begin
							nh  = 2'd1;
							nb0 = in_byte;
						end else begin
							nh    = 2'd0;
							cand1 = upd_pkg::map_plus(in_byte);
							cv1   = 1'b1;
						end
					end
				end
				default: begin
					nh = 2'd0;
				end
			endcase
			if (in_last) begin
				nh = 2'd0;
			end
		end
	end

	always_comb begin
		e1  = {1'b0, emitted} + 17'd1;
		e2  = {1'b0, emitted} + 17'd2;
		ok0 = cv0 && (e1 < {1'b0, capacity});
		ok1 = ok0 && cv1 && (e2 < {1'b0, capacity});
		k   = {1'b0, ok0} + {1'b0, ok1};

		dec.w0.data = cand0;
		dec.w0.has  = 1'b1;
		dec.w0.last = in_last && !ok1;
		dec.w1.data = cand1;
		dec.w1.has  = 1'b1;
		dec.w1.last = in_last;
		dec.n       = k;
		if (in_last && !ok0) begin
			dec.w0.data = 8'd0;
			dec.w0.has  = 1'b0;
			dec.w0.last = 1'b1;
			dec.n       = 2'd1;
		end
		dec.held_cnt = nh;
		dec.held_b0  = nb0;
		dec.held_b1  = nb1;
		dec.emitted  = in_last ? 16'd0 : (emitted + {14'd0, k});
	end

endmodule

@@ sv/upd_outq.sv @@
// Two-word result register that presents decoded words one per cycle while m_tready is high.
module upd_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  upd_pkg::word_t w0,
	input  upd_pkg::word_t w1,
	input  logic [1:0]     n,
	output logic           free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,  // out_byte[7:0]
	output logic           m_tuser,  // out_has_byte
	output logic           m_tlast
);

	upd_pkg::word_t slot0_q;
	upd_pkg::word_t slot1_q;
	logic [1:0]     rem_q;
	logic           pop;

	assign pop      = m_tvalid && m_tready;
	assign free     = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = slot0_q.data;
	assign m_tuser  = slot0_q.has;
	assign m_tlast  = slot0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= n;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= w0;
			slot1_q <= w1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

@@ sv/url_percent_decoder.sv @@
// Top level of the form-urlencoded percent decoder.
// The decoder takes one encoded character per word and turns a plus into a space and a
// percent sign with two hex digits into one byte, holding at most two characters of
// lookahead. An input word is registered, decoded combinationally and written into a
// two-word result register that drives the output one word per cycle while m_tready is
// high. A word with no result or one result lets the input run at one word per cycle
// while m_tready is high; a word that resolves two bytes fills both result slots, and
// the input stalls until the first is taken. The capacity register (reset 65) limits
// each string to capacity minus one output bytes, and the rest of the string is consumed
// without output; the user must write it only while idle; the block does not enforce it.
module url_percent_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tuser,   // in_has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tuser,   // out_has_byte
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          has_s1;
	logic          last_s1;
	logic [1:0]    held_cnt_q;
	logic [7:0]    held_b0_q;
	logic [7:0]    held_b1_q;
	logic [15:0]   emitted_q;
	logic [15:0]   capacity_q;
	upd_pkg::dec_t dec;
	logic          out_free;
	logic          fire;
	logic          load;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && ((dec.n == 2'd0) || out_free);
	assign load      = fire && (dec.n != 2'd0);
	assign s_tready  = !valid_s1 || fire;

	upd_decode u_decode (
		.held_cnt    (held_cnt_q),
		.held_b0     (held_b0_q),
		.held_b1     (held_b1_q),
		.emitted     (emitted_q),
		.capacity    (capacity_q),
		.in_byte     (byte_s1),
		.in_has_byte (has_s1),
		.in_last     (last_s1),
		.dec         (dec)
	);

	upd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.w0       (dec.w0),
		.w1       (dec.w1),
		.n        (dec.n),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			has_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			held_b0_q  <= 8'd0;
			held_b1_q  <= 8'd0;
			emitted_q  <= 16'd0;
		end else if (fire) begin
			held_cnt_q <= dec.held_cnt;
			held_b0_q  <= dec.held_b0;
			held_b1_q  <= dec.held_b1;
			emitted_q  <= dec.emitted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= upd_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder: a directed table, then random strings.
module testbench;

	localparam int RUN_LIMIT = 400000;
	localparam int ROWS = 27;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
		logic       typed;
		logic [1:0] count;
		logic [7:0] b0;
		logic       h0;
		logic       l0;
		logic [7:0] b1;
		logic       h1;
		logic       l1;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // in_byte[7:0]
	logic        s_tuser;   // in_has_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte[7:0]
	logic        m_tuser;   // out_has_byte
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	out_word_t   want_q[$];
	out_word_t   step_out[$];
	out_word_t   got_want;
	row_t        dir_rows [0:ROWS-1];
	logic [15:0] phase_caps [0:PHASES-1];

	logic [15:0] capacity;
	int          waiting_n;
	logic [7:0]  waiting [0:1];
	logic [15:0] out_n;

	int          errors;
	int          words_sent;
	int          strings_sent;
	int          results_seen;
	int          settings_used;
	int          hold_req;
	int          cycle_count;
	int unsigned send_idle;
	int unsigned recv_idle;

	url_percent_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void put_out(input logic [7:0] b);
		if (({16'd0, out_n} + 32'd1) < {16'd0, capacity}) begin
			step_out.push_back({b, 1'b1, 1'b0});
			out_n = out_n + 16'd1;
		end
	endfunction

	// Works out the decoded words caused by one input word and advances the lookahead.
	function automatic void decode_word(input logic [7:0] b, input logic h, input logic l);
		logic [7:0] q [0:2];
		int         n;
		int         i;
		int         hi;
		int         lo;
		logic       stall;
		out_word_t  w;
		step_out.delete();
		if (!h && !l) return;
		q[0] = 8'h00;
		q[1] = 8'h00;
		q[2] = 8'h00;
		n = 0;
		for (i = 0; i < waiting_n; i++) begin
			q[n] = waiting[i];
			n++;
		end
		if (h) begin
			q[n] = b;
			n++;
		end
		stall = 1'b0;
		while (n > 0 && !stall) begin
			if (q[0] == upd_pkg::CH_PERCENT && n < 3) begin
				if (l) begin
					put_out(q[0]);
					q[0] = q[1];
					q[1] = q[2];
					n--;
				end else begin
					stall = 1'b1;
				end
			end else if (q[0] == upd_pkg::CH_PERCENT) begin
				hi = hex_digit(q[1]);
				lo = hex_digit(q[2]);
				if (hi >= 0 && lo >= 0) begin
					put_out(8'(hi * 16 + lo));
					n = 0;
				end else begin
					q[0] = q[1];
					q[1] = q[2];
					n--;
				end
			end else begin
				put_out(q[0] == upd_pkg::CH_PLUS ? upd_pkg::CH_SPACE : q[0]);
				q[0] = q[1];
				q[1] = q[2];
				n--;
			end
		end
		if (l) begin
			if (step_out.size() == 0) begin
				step_out.push_back({8'h00, 1'b0, 1'b1});
			end else begin
				w = step_out[step_out.size() - 1];
				w.last = 1'b1;
				step_out[step_out.size() - 1] = w;
			end
			waiting_n = 0;
			waiting[0] = 8'h00;
			waiting[1] = 8'h00;
			out_n = 16'd0;
		end else begin
			waiting_n = n;
			waiting[0] = q[0];
			waiting[1] = q[1];
		end
	endfunction

	function automatic logic [7:0] rand_hex();
		int unsigned r;
		r = $urandom_range(21);
		if (r < 10) return 8'h30 + 8'(r);
		if (r < 16) return 8'h61 + 8'(r - 10);
		return 8'h41 + 8'(r - 16);
	endfunction

	function automatic logic [7:0] near_hex();
		logic [7:0] c;
		case ($urandom_range(5))
			0: c = 8'h2F;
			1: c = 8'h3A;
			2: c = 8'h40;
			3: c = 8'h47;
			4: c = 8'h60;
			default: c = 8'h67;
		endcase
		return c;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic h, input logic l,
		input logic use_model);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= h;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_word(b, h, l);
		if (use_model) begin
			foreach (step_out[i]) want_q.push_back(step_out[i]);
		end
		if (h || l) words_sent++;
		if (l) strings_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		capacity = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_string(input int len, input bit plain, input bit pause);
		int          k;
		int unsigned sel;
		for (k = 0; k < len; k++) begin
			sel = plain ? 0 : $urandom_range(99);
			if (sel < 35) begin
				send_word(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
			end else if (sel < 55) begin
				send_word(upd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b1);
				send_word(rand_hex(), 1'b1, 1'b0, 1'b1);
				send_word(rand_hex(), 1'b1, 1'b0, 1'b1);
			end else if (sel < 65) begin
				send_word(upd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b1);
				send_word($urandom_range(1) ? rand_hex() : near_hex(), 1'b1, 1'b0, 1'b1);
				send_word($urandom_range(1) ? near_hex() : 8'($urandom_range(255)),
					1'b1, 1'b0, 1'b1);
			end else if (sel < 75) begin
				send_word(upd_pkg::CH_PLUS, 1'b1, 1'b0, 1'b1);
			end else if (sel < 82) begin
				send_word(upd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b1);
			end else if (sel < 90) begin
				send_word(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
			end else begin
				send_word(rand_hex(), 1'b1, 1'b0, 1'b1);
			end
		end
		if (pause) settle();
		sel = $urandom_range(99);
		if (sel < 25) begin
			send_word(8'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
		end else if (sel < 40) begin
			send_word(upd_pkg::CH_PERCENT, 1'b1, 1'b1, 1'b1);
		end else if (sel < 55) begin
			send_word(rand_hex(), 1'b1, 1'b1, 1'b1);
		end else begin
			send_word(8'($urandom_range(255)), 1'b1, 1'b1, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word data=%h has=%b last=%b", $time,
					m_tdata, m_tuser, m_tlast);
			end else begin
				got_want = want_q.pop_front();
				if (got_want.data !== m_tdata || got_want.has !== m_tuser ||
					got_want.last !== m_tlast) begin
					errors++;
					$display("%0t: mismatch expected data=%h has=%b last=%b, got data=%h has=%b last=%b",
						$time, got_want.data, got_want.has, got_want.last,
						m_tdata, m_tuser, m_tlast);
				end
			end
		end
	end

	initial begin
		int hold_done;
		int hold_left;
		hold_done = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_done != hold_req) begin
				hold_done = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int   r;
		int   p;
		int   start;
		row_t row;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		errors = 0;
		words_sent = 0;
		strings_sent = 0;
		results_seen = 0;
		settings_used = 1;
		hold_req = 0;
		capacity = upd_pkg::CAPACITY_RESET;
		waiting_n = 0;
		waiting[0] = 8'h00;
		waiting[1] = 8'h00;
		out_n = 16'd0;
		send_idle = 34;
		recv_idle = 51;
		phase_caps = '{16'd3, 16'd1, 16'd65535, 16'd2, 16'd65, 16'd17};
		dir_rows = '{
			'{8'h00, 1'b0, 1'b1, 1'b1, 2'd1, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
			'{8'h61, 1'b1, 1'b0, 1'b1, 2'd1, 8'h61, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h2B, 1'b1, 1'b1, 1'b1, 2'd1, 8'h20, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h34, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h31, 1'b1, 1'b1, 1'b1, 2'd1, 8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h66, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h46, 1'b1, 1'b0, 1'b1, 2'd1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h5A, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h30, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h30, 1'b1, 1'b0, 1'b1, 2'd1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b1, 1'b1, 2'd1, 8'h25, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h47, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h48, 1'b1, 1'b1, 1'b1, 2'd2, 8'h47, 1'b1, 1'b0, 8'h48, 1'b1, 1'b1},
			'{8'h25, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h41, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b1, 2'd2, 8'h25, 1'b1, 1'b0, 8'h41, 1'b1, 1'b1},
			'{8'h25, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h25, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h43, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h7A, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'h80, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
			'{8'hFF, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < ROWS; r++) begin
			row = dir_rows[r];
			send_word(row.data, row.has, row.last, !row.typed);
			if (row.typed && row.count > 0) want_q.push_back({row.b0, row.h0, row.l0});
			if (row.typed && row.count > 1) want_q.push_back({row.b1, row.h1, row.l1});
		end
		settle();

		for (p = 0; p < PHASES; p++) begin
			send_idle = (p < 2) ? 34 : (p < 4) ? 51 : 0;
			recv_idle = (p < 2) ? 51 : (p < 4) ? 34 : 0;
			write_capacity(phase_caps[p]);
			if (p == 4) hold_req++;
			start = words_sent;
			if (phase_caps[p] < 16'd100) send_string(int'(phase_caps[p]) + 3, 1'b1, 1'b0);
			while (words_sent - start < PHASE_WORDS) begin
				send_string($urandom_range(12), 1'b0, p == 5 && words_sent - start < 25);
			end
			settle();
		end

		repeat (10) @(posedge clk);
		$display("Run covered %0d words in %0d strings and %0d checked results,",
			words_sent, strings_sent, results_seen);
		$display("over %0d capacity settings from 1 to 65535 with stalls on both sides.",
			settings_used);
		if (errors == 0 && want_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/upd_pkg.sv
sv/upd_decode.sv
sv/upd_outq.sv
sv/url_percent_decoder.sv
tb/testbench.sv
